[rtl/core/sst_pkg.sv]
// Shared types, codes and sizes for the sorted sprite depth table.
`default_nettype none
package sst_pkg;

  localparam int unsigned MAX_SPRITES_DEF = 256;
  localparam int unsigned SPRITE_W        = 8;
  localparam int unsigned DEPTH_W         = 16;
  localparam int unsigned SLOT_W          = 8;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_DRAIN = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOALLOC = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [DEPTH_W-1:0]  depth;
    logic [SPRITE_W-1:0] sprite;
    logic [SLOT_W-1:0]   slot;
  } ent_t;

  typedef struct packed {
    logic                set_a;
    logic [SPRITE_W-1:0] id_a;
    logic                set_b;
    logic [SPRITE_W-1:0] id_b;
    logic                clr;
    logic [SPRITE_W-1:0] id_clr;
  } dirty_req_t;

endpackage
`default_nettype wire

[rtl/core/sst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/sst_dirty.sv]
// Dirty flag store with a count of set flags.
`default_nettype none
module sst_dirty
  import sst_pkg::*;
#(
  parameter int unsigned MAX_SPRITES = MAX_SPRITES_DEF,
  localparam int unsigned AW = $clog2(MAX_SPRITES),
  localparam int unsigned CW = $clog2(MAX_SPRITES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dirty_req_t    req_i,
  input  wire logic [AW-1:0] rd_idx_i,
  output logic               rd_flag_o,
  output logic               pending_o
);

  logic [MAX_SPRITES-1:0] flags_q, flags_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]          ia, ib, ic;
  logic                   inc_a, inc_b, dec_c;

  assign ia = req_i.id_a[AW-1:0];
  assign ib = req_i.id_b[AW-1:0];
  assign ic = req_i.id_clr[AW-1:0];

  always_comb begin
    flags_d = flags_q;
    inc_a   = req_i.set_a && !flags_q[ia];
    inc_b   = req_i.set_b && !flags_q[ib] && !(req_i.set_a && ia == ib);
    dec_c   = req_i.clr && flags_q[ic];
    if (req_i.set_a) flags_d[ia] = 1'b1;
    if (req_i.set_b) flags_d[ib] = 1'b1;
    if (req_i.clr)   flags_d[ic] = 1'b0;
    cnt_d = cnt_q + CW'(inc_a) + CW'(inc_b) - CW'(dec_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      cnt_q   <= '0;
    end else begin
      flags_q <= flags_d;
      cnt_q   <= cnt_d;
    end
  end

  assign rd_flag_o = flags_q[rd_idx_i];
  assign pending_o = (cnt_q != '0);

endmodule
`default_nettype wire

[rtl/core/sorted_sprite_depth_table.sv]
// Top level of the sorted sprite depth table: sequencer around the entry store.
//
// The block keeps up to MAX_SPRITES sprites in a list sorted by rising 16-bit
// depth; each entry also carries a hardware slot, and slots rise along the
// list too. Pulse start with mode_i (0 allocate, 1 set depth, 2 drain one
// changed sprite) while busy is low; exactly one result comes back later on
// the output ports, marked by a one-cycle done_o strobe. The receiver cannot
// stall: capture the result in the cycle done_o is high. All list work goes
// through one entry RAM with a single read port and registered read data, so
// each entry scanned, shifted or slot-swapped takes a read state and then a
// check or write state. A depth change that moves an entry across the whole
// list searches, shifts and re-bubbles every entry. A drain walks the dirty
// flags one per cycle. Errors (pool full, unallocated sprite) and the unused
// mode answer in the cycle right after the accepting edge, with busy staying
// low. The dirty flags are flip-flops cleared by reset, so no clearing pass
// runs; list entries never written read as anything, but are never used.
`default_nettype none
module sorted_sprite_depth_table
  import sst_pkg::*;
#(
  parameter int unsigned MAX_SPRITES = MAX_SPRITES_DEF,
  localparam int unsigned AW = $clog2(MAX_SPRITES),
  localparam int unsigned CW = $clog2(MAX_SPRITES + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          mode_i,
  input  wire logic [SPRITE_W-1:0] sprite_id_i,
  input  wire logic [DEPTH_W-1:0]  depth_value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [SPRITE_W-1:0]      sprite_out_o,
  output logic [7:0]               list_position_o,
  output logic [SLOT_W-1:0]        hw_slot_o,
  output logic                     more_pending_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_M_POS, S_M_ENT, S_DN_RD, S_DN_CHK, S_UP_RD,
    S_UP_CHK, S_MV, S_SH_RD, S_SH_WR, S_PLACE, S_BD_RD, S_BD_CHK, S_BU_RD,
    S_BU_CHK, S_FIN_WR, S_FIN_RD, S_FIN_OUT, S_D_CHK, S_D_POS, S_D_ENT
  } state_e;

  localparam logic [CW-1:0] MAX_C = CW'(MAX_SPRITES);

  state_e               state_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        idx_q;
  logic [AW-1:0]        src_q, dst_q;
  logic                 shift_up_q;
  ent_t                 hk_q;
  logic [DEPTH_W-1:0]   depth_q;
  logic [SPRITE_W-1:0]  sid_q;
  logic                 done_q, more_q;
  logic [1:0]           status_q;
  logic [SPRITE_W-1:0]  spr_q;
  logic [7:0]           pos_q;
  logic [SLOT_W-1:0]    slot_q;

  logic [AW-1:0]        idx_a, idx_m1, idx_p1, tail;
  logic [SPRITE_W-1:0]  newid;
  logic                 accept;

  logic                 ent_we;
  logic [AW-1:0]        ent_waddr, ent_raddr;
  ent_t                 ent_wdata, ent_rd;
  logic [$bits(ent_t)-1:0] ent_rdata;
  logic                 pos_we;
  logic [AW-1:0]        pos_waddr, pos_wdata, pos_raddr, pos_rdata;
  dirty_req_t           dreq;
  logic                 dflag, pending;

  assign idx_a  = idx_q[AW-1:0];
  assign idx_m1 = idx_a - 1'b1;
  assign idx_p1 = idx_a + 1'b1;
  assign tail   = AW'(count_q - 1'b1);
  assign newid  = SPRITE_W'(count_q);
  assign accept = start && !busy;
  assign ent_rd = ent_t'(ent_rdata);

  sst_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_SPRITES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  sst_ram #(.WIDTH(AW), .DEPTH(MAX_SPRITES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  sst_dirty #(.MAX_SPRITES(MAX_SPRITES)) u_dirty (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (dreq),
    .rd_idx_i  (idx_a),
    .rd_flag_o (dflag),
    .pending_o (pending)
  );

  // Memory and dirty-store controls for the current step.
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = idx_a;
    ent_wdata = hk_q;
    ent_raddr = idx_a;
    pos_we    = 1'b0;
    pos_waddr = hk_q.sprite[AW-1:0];
    pos_wdata = dst_q;
    pos_raddr = sprite_id_i[AW-1:0];
    dreq      = '0;
    unique case (state_q)
      S_M_POS, S_D_POS: ent_raddr = pos_rdata;
      S_DN_RD, S_BD_RD: ent_raddr = idx_m1;
      S_UP_RD, S_BU_RD: ent_raddr = idx_p1;
      S_FIN_RD:         ent_raddr = dst_q;
      S_SH_WR: begin
        // Move one entry a place toward the vacated slot.
        ent_we      = 1'b1;
        ent_waddr   = shift_up_q ? idx_m1 : idx_p1;
        ent_wdata   = ent_rd;
        pos_we      = 1'b1;
        pos_waddr   = ent_rd.sprite[AW-1:0];
        pos_wdata   = ent_waddr;
        dreq.set_a  = 1'b1;
        dreq.id_a   = ent_rd.sprite;
      end
      S_PLACE: begin
        pos_we     = 1'b1;
        dreq.set_a = 1'b1;
        dreq.id_a  = hk_q.sprite;
      end
      S_BD_CHK, S_BU_CHK: begin
        if ((state_q == S_BD_CHK && !(hk_q.slot > ent_rd.slot)) ||
            (state_q == S_BU_CHK && !(hk_q.slot < ent_rd.slot))) begin
          ent_we     = 1'b1;
          ent_wdata  = '{depth: hk_q.depth, sprite: hk_q.sprite, slot: ent_rd.slot};
          dreq.set_a = 1'b1;
          dreq.id_a  = hk_q.sprite;
          dreq.set_b = 1'b1;
          dreq.id_b  = ent_rd.sprite;
        end
      end
      S_FIN_WR: ent_we = 1'b1;
      S_D_CHK: begin
        pos_raddr = idx_a;
        if (idx_q != MAX_C && dflag) begin
          dreq.clr    = 1'b1;
          dreq.id_clr = SPRITE_W'(idx_q);
        end
      end
      default: ;
    endcase
  end

  // Sequencer and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      idx_q      <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      shift_up_q <= 1'b0;
      hk_q       <= '0;
      depth_q    <= '0;
      sid_q      <= '0;
      done_q     <= 1'b0;
      status_q   <= ST_DONE;
      spr_q      <= '0;
      pos_q      <= '0;
      slot_q     <= '0;
      more_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            depth_q <= depth_value_i;
            idx_q   <= '0;
            case (mode_i)
              MODE_ALLOC: begin
                if (count_q >= MAX_C) begin
                  done_q <= 1'b1; status_q <= ST_FULL; more_q <= pending;
                  spr_q <= '0; pos_q <= '0; slot_q <= '0;
                end else begin
                  hk_q    <= '{depth: depth_value_i, sprite: newid, slot: ~newid};
                  sid_q   <= newid;
                  src_q   <= AW'(count_q);
                  count_q <= count_q + 1'b1;
                  state_q <= S_A_RD;
                end
              end
              MODE_SET: begin
                if (9'(sprite_id_i) >= 9'(count_q)) begin
                  done_q <= 1'b1; status_q <= ST_NOALLOC; more_q <= pending;
                  spr_q <= '0; pos_q <= '0; slot_q <= '0;
                end else begin
                  sid_q   <= sprite_id_i;
                  state_q <= S_M_POS;
                end
              end
              MODE_DRAIN: state_q <= S_D_CHK;
              default: begin
                done_q <= 1'b1; status_q <= ST_DONE; more_q <= pending;
                spr_q <= '0; pos_q <= '0; slot_q <= '0;
              end
            endcase
          end
        end
        // Allocate: find the first entry deeper than the new one.
        S_A_RD: begin
          if (idx_a == src_q) begin
            dst_q   <= src_q;
            state_q <= S_PLACE;
          end else begin
            state_q <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (depth_q < ent_rd.depth) begin
            dst_q      <= idx_a;
            shift_up_q <= 1'b0;
            idx_q      <= CW'(src_q - 1'b1);
            state_q    <= S_SH_RD;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_A_RD;
          end
        end
        // Set depth: fetch the current place and entry.
        S_M_POS: begin
          src_q   <= pos_rdata;
          idx_q   <= CW'(pos_rdata);
          state_q <= S_M_ENT;
        end
        S_M_ENT: begin
          hk_q    <= '{depth: depth_q, sprite: ent_rd.sprite, slot: ent_rd.slot};
          state_q <= S_DN_RD;
        end
        S_DN_RD:  state_q <= (idx_a == '0) ? S_UP_RD : S_DN_CHK;
        S_DN_CHK: begin
          if (depth_q < ent_rd.depth) begin
            idx_q   <= idx_q - 1'b1;
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_UP_RD;
          end
        end
        S_UP_RD:  state_q <= (idx_a == tail) ? S_MV : S_UP_CHK;
        S_UP_CHK: begin
          if (depth_q > ent_rd.depth) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_MV;
          end
        end
        S_MV: begin
          dst_q <= idx_a;
          if (idx_a == src_q) begin
            state_q <= S_FIN_WR;
          end else if (idx_a < src_q) begin
            shift_up_q <= 1'b0;
            idx_q      <= CW'(src_q - 1'b1);
            state_q    <= S_SH_RD;
          end else begin
            shift_up_q <= 1'b1;
            idx_q      <= CW'(src_q + 1'b1);
            state_q    <= S_SH_RD;
          end
        end
        // Shift the entries between the old and new place.
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          if (idx_a == dst_q) begin
            state_q <= S_PLACE;
          end else begin
            idx_q   <= shift_up_q ? idx_q + 1'b1 : idx_q - 1'b1;
            state_q <= S_SH_RD;
          end
        end
        S_PLACE: begin
          idx_q   <= CW'(dst_q);
          state_q <= S_BD_RD;
        end
        // Bubble the moved slot down, then up, until slots rise again.
        S_BD_RD:  state_q <= (idx_a == '0) ? S_BU_RD : S_BD_CHK;
        S_BD_CHK: begin
          if (hk_q.slot > ent_rd.slot) begin
            state_q <= S_BU_RD;
          end else begin
            hk_q    <= '{depth: ent_rd.depth, sprite: ent_rd.sprite, slot: hk_q.slot};
            idx_q   <= idx_q - 1'b1;
            state_q <= S_BD_RD;
          end
        end
        S_BU_RD:  state_q <= (idx_a == tail) ? S_FIN_WR : S_BU_CHK;
        S_BU_CHK: begin
          if (hk_q.slot < ent_rd.slot) begin
            state_q <= S_FIN_WR;
          end else begin
            hk_q    <= '{depth: ent_rd.depth, sprite: ent_rd.sprite, slot: hk_q.slot};
            idx_q   <= idx_q + 1'b1;
            state_q <= S_BU_RD;
          end
        end
        S_FIN_WR: state_q <= S_FIN_RD;
        S_FIN_RD: state_q <= S_FIN_OUT;
        S_FIN_OUT: begin
          done_q <= 1'b1; status_q <= ST_DONE; more_q <= pending;
          spr_q <= sid_q; pos_q <= 8'(dst_q); slot_q <= ent_rd.slot;
          state_q <= S_IDLE;
        end
        // Drain: walk the flags, lowest sprite first.
        S_D_CHK: begin
          if (idx_q == MAX_C) begin
            done_q <= 1'b1; status_q <= ST_EMPTY; more_q <= pending;
            spr_q <= '0; pos_q <= '0; slot_q <= '0;
            state_q <= S_IDLE;
          end else if (dflag) begin
            sid_q   <= SPRITE_W'(idx_q);
            state_q <= S_D_POS;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_D_POS: begin
          dst_q   <= pos_rdata;
          state_q <= S_D_ENT;
        end
        S_D_ENT: begin
          done_q <= 1'b1; status_q <= ST_DONE; more_q <= pending;
          spr_q <= sid_q; pos_q <= 8'(dst_q); slot_q <= ent_rd.slot;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign sprite_out_o    = spr_q;
  assign list_position_o = pos_q;
  assign hw_slot_o       = slot_q;
  assign more_pending_o  = more_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_C)
    else $error("sprite count above pool size");

  a_full_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_ALLOC && count_q >= MAX_C) |=>
      (done_o && status_o == ST_FULL && count_q == MAX_C))
    else $error("full pool not reported");

  a_empty_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> !more_pending_o)
    else $error("empty drain claims pending sprites");

  a_alloc_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_ALLOC && count_q < MAX_C) |=>
      (count_q == $past(count_q) + 1'b1 && busy))
    else $error("allocate did not take a sprite");

endmodule
`default_nettype wire
